// ===== sv/cbf_pkg.sv =====
// Package for the counting Bloom filter: request, status and configuration codes, controller states, datapath structs.
// No dependencies.
package cbf_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CHECK  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_CELL_COUNT = 2'd0,
    CFG_CELL_BITS  = 2'd1,
    CFG_HASH_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_READ  = 6'b001000,
    S_UPD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // capture hash word, start modulo
    logic clr_start; // start a clearing sweep
    logic clr_step;  // write zero at sweep address
    logic mod_step;  // one modulo iteration
    logic rd;        // issue cell read
    logic wr;        // write back updated cell
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic mod_done;
    logic clr_done;
    logic fail;      // the cell just read fails the request
  } dp_stat_t;

endpackage

// ===== sv/counting_bloom_filter.sv =====
// Counting Bloom filter store, top level: configuration registers and clamping.
// Depends on cbf_pkg, cbf_ctrl, cbf_datapath.
//
// Usage: a request is hash_count items on the input channel (in_valid_i /
// in_stall_o), each with one hash word; req_type_i is sampled on the first
// item only. A clear request is one item. One status result per request
// leaves on the output channel (out_valid_o / out_stall_i).
// Each hash item runs through the bit-serial modulo unit (64 quotient bits,
// one a cycle, plus the done check), then cell read, update/write-back,
// bookkeeping and a return to idle; the input stalls until then.
// The status is registered at the bookkeeping step of the last item of a request.
// A clear zeroes all MAX_CELLS cells, one cell written per cycle; its result
// is posted at once. At reset the same sweep zeroes the store: the input is
// stalled until the sweep ends, configuration writes are taken throughout.
// A result waits in the output register while the receiver stalls; the next
// request runs on and only stops before posting its own result (a clear
// waits at the input until the register is free).
// Configuration: cfg_valid_i/cfg_ready_o with index and data; index 0
// cell_count, 1 cell_bits, 2 hash_count, others ignored.
module counting_bloom_filter #(
  parameter int MAX_CELLS     = 4096,
  parameter int MAX_CELL_BITS = 8,
  parameter int MAX_HASHES    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] hash_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import cbf_pkg::*;

  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int BW = MAX_CELL_BITS;

  logic [12:0] cc_q;
  logic [3:0]  cb_q;
  logic [4:0]  hc_q;
  logic [CW-1:0] cells;
  logic [BW-1:0] mask;
  logic [5:0]  bits;
  logic [4:0]  hc;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  req_type_e kind;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 13'd4096;
      cb_q <= 4'd4;
      hc_q <= 5'd4;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CELL_COUNT: cc_q <= cfg_data_i;
        CFG_CELL_BITS:  cb_q <= cfg_data_i[3:0];
        CFG_HASH_COUNT: hc_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Clamped effective values
  always_comb begin
    if (cc_q == '0) cells = CW'(1);
    else if (32'(cc_q) > MAX_CELLS) cells = CW'(MAX_CELLS);
    else cells = CW'(cc_q);
    if (cb_q == '0) bits = 6'd1;
    else if (32'(cb_q) > MAX_CELL_BITS) bits = 6'(MAX_CELL_BITS);
    else bits = 6'(cb_q);
    if (hc_q == '0) hc = 5'd1;
    else if (32'(hc_q) > MAX_HASHES) hc = 5'(MAX_HASHES);
    else hc = hc_q;
    for (int i = 0; i < BW; i++) mask[i] = (6'(i) < bits);
  end

  cbf_ctrl #(.MAX_HASHES(MAX_HASHES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .req_type_i (req_type_e'(req_type_i)),
    .hc_i       (hc),
    .out_valid_o, .out_stall_i, .status_o,
    .cmd_o      (cmd),
    .kind_o     (kind),
    .stat_i     (stat)
  );

  cbf_datapath #(.MAX_CELLS(MAX_CELLS), .MAX_CELL_BITS(MAX_CELL_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .hash_word_i (hash_word_i),
    .cells_i     (cells),
    .mask_i      (mask),
    .kind_i      (kind),
    .stat_o      (stat)
  );
endmodule

// ===== sv/cbf_datapath.sv =====
// Datapath: bit-serial 64-bit modulo unit, cell memory with read-modify-write, clear sweep.
// Depends on cbf_pkg.
module cbf_datapath #(
  parameter int MAX_CELLS     = 4096,
  parameter int MAX_CELL_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cbf_pkg::dp_cmd_t                   cmd_i,
  input  logic [63:0]                        hash_word_i,
  input  logic [$clog2(MAX_CELLS+1)-1:0]     cells_i,
  input  logic [MAX_CELL_BITS-1:0]           mask_i,
  input  cbf_pkg::req_type_e                 kind_i,
  output cbf_pkg::dp_stat_t                  stat_o
);
  import cbf_pkg::*;

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int BW = MAX_CELL_BITS;

  logic [BW-1:0] mem_q [MAX_CELLS];
  logic [63:0]   quo_q, quo_d;
  logic [CW:0]   rem_q, rem_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [BW-1:0] rd_q;
  logic [CW:0]   trial;
  logic [BW-1:0] val, newv;

  // Restoring division: one quotient bit per cycle while mod_step is set
  always_comb begin
    trial = {rem_q[CW-1:0], quo_q[63]};
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      quo_d = hash_word_i;
      rem_d = '0;
      cnt_d = 7'd0;
    end else if (cmd_i.mod_step) begin
      quo_d = {quo_q[62:0], 1'b0};
      if (trial >= {1'b0, cells_i}) rem_d = trial - {1'b0, cells_i};
      else                          rem_d = trial;
      cnt_d = cnt_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 7'd64;
      clr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // Clear sweep address
  always_comb begin
    clr_d = clr_q;
    if (cmd_i.clr_start)     clr_d = '0;
    else if (cmd_i.clr_step) clr_d = clr_q + AW'(1);
  end

  // Cell update
  assign val  = rd_q & mask_i;
  assign newv = (kind_i == REQ_ADD) ? ((val + BW'(1)) & mask_i)
                                    : ((val - BW'(1)) & mask_i);

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step)  mem_q[clr_q] <= '0;
    else if (cmd_i.wr)   mem_q[rem_q[AW-1:0]] <= newv;
    if (cmd_i.rd)        rd_q <= mem_q[rem_q[AW-1:0]];
  end

  always_comb begin
    stat_o.mod_done = (cnt_q == 7'd64);
    stat_o.clr_done = (clr_q == AW'(MAX_CELLS - 1));
    unique case (kind_i)
      REQ_ADD: stat_o.fail = (val == mask_i);
      default: stat_o.fail = (val == '0);
    endcase
  end
endmodule

// ===== sv/cbf_ctrl.sv =====
// Controller: request sequencing, hash position, failure flag, clear sweep and result register.
// Depends on cbf_pkg.
module cbf_ctrl #(
  parameter int MAX_HASHES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cbf_pkg::req_type_e  req_type_i,
  input  logic [4:0]          hc_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output cbf_pkg::dp_cmd_t    cmd_o,
  output cbf_pkg::req_type_e  kind_o,
  input  cbf_pkg::dp_stat_t   stat_i
);
  import cbf_pkg::*;

  localparam int PW = $clog2(MAX_HASHES + 1);

  state_e    state_q, state_d;
  req_type_e kind_q, kind_d;
  logic      fail_q, fail_d;
  logic [PW-1:0] pos_q, pos_d;
  logic      ov_q, ov_d;
  logic [1:0] st_q, st_d;
  logic      acc, last;
  logic [1:0] res;

  assign kind_o      = kind_q;
  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  // a clear posts its result at once, so it waits for a free result register
  assign in_stall_o  = (state_q != S_IDLE) ||
                       (ov_q && pos_q == '0 && req_type_i == REQ_CLEAR);
  assign acc         = in_valid_i && !in_stall_o;
  assign last        = (32'(pos_q) + 32'd1) >= 32'(hc_i);

  always_comb begin
    unique case (kind_q)
      REQ_ADD:   res = ST_OVERFLOW;
      REQ_CHECK: res = ST_ABSENT;
      default:   res = ST_UNDERFLOW;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    fail_d  = fail_q;
    pos_d   = pos_q;
    ov_d    = ov_q && out_stall_i;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (pos_q == '0) begin
            kind_d = req_type_i;
            fail_d = 1'b0;
          end
          if (pos_q == '0 && req_type_i == REQ_CLEAR) begin
            cmd_o.clr_start = 1'b1;
            ov_d  = 1'b1;
            st_d  = ST_OK;
            state_d = S_CLEAR;
          end else begin
            cmd_o.load = 1'b1;
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (stat_i.mod_done) state_d = S_READ;
        else cmd_o.mod_step = 1'b1;
      end
      S_READ: begin
        cmd_o.rd = !fail_q;
        state_d  = S_UPD;
      end
      S_UPD: begin
        if (!fail_q) begin
          if (stat_i.fail) fail_d = 1'b1;
          cmd_o.wr = (kind_q != REQ_CHECK);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // on the last item, hold here while the previous result still waits
        if (last) begin
          if (!(ov_q && out_stall_i)) begin
            ov_d    = 1'b1;
            st_d    = fail_q ? res : ST_OK;
            pos_d   = '0;
            fail_d  = 1'b0;
            state_d = S_IDLE;
          end
        end else begin
          pos_d   = pos_q + PW'(1);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kind_q  <= REQ_ADD;
      fail_q  <= 1'b0;
      pos_q   <= '0;
      ov_q    <= 1'b0;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      fail_q  <= fail_d;
      pos_q   <= pos_d;
      ov_q    <= ov_d;
      st_q    <= st_d;
    end
  end
endmodule
